@@ rtl/mlfc_pkg.sv @@
// Shared types and constants for the motion light fade controller.
// No dependencies; every other file refers to this package by scoped names.
package mlfc_pkg;

    // Light modes as reported on the result channel
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_TO_WHITE = 3'd1,
        MODE_TO_RED   = 3'd2,
        MODE_TO_OFF   = 3'd3,
        MODE_WHITE    = 3'd4,
        MODE_RED      = 3'd5
    } light_mode_t;

    // Request operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_FADE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEVEL_MAX  = 2'd0;
    localparam logic [1:0] CFG_WHITE_MIN  = 2'd1;
    localparam logic [1:0] CFG_WHITE_MAX  = 2'd2;
    localparam logic [1:0] CFG_RED_TIME   = 2'd3;

    // Configuration reset values
    localparam logic [7:0] LEVEL_MAX_RST = 8'h2F;
    localparam logic [9:0] WHITE_MIN_RST = 10'd60;
    localparam logic [9:0] WHITE_MAX_RST = 10'd600;
    localparam logic [9:0] RED_TIME_RST  = 10'd60;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // One LED entry
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    // Input request
    typedef struct packed {
        logic [1:0] op;
        logic       motion;
        logic       ambient_dark;
        logic [6:0] led_index;
    } in_item_t;

    // Result
    typedef struct packed {
        logic [2:0] mode;
        logic [9:0] timeout_left;
        logic       frame_send;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } out_item_t;

endpackage

@@ rtl/motion_light_fade_controller_core.sv @@
// Top level of the motion light fade controller: sequencer, timeout logic,
// configuration registers and result register. Uses mlfc_pkg, mlfc_led_ram
// and mlfc_pixel_step.
//
//  Channel   Ports                        Direction  Content
//  s_        s_valid s_ready s_payload    in         in_item_t request
//  m_        m_valid m_ready m_payload    out        out_item_t result
//  cfg_      cfg_valid cfg_ready          in         cfg_index, cfg_data
//
// Path from the accepting edge to the edge that raises m_valid: a tick, an
// unused op or a fade step outside a fade goes through ST_OUT; a read first
// passes ST_READ (registered memory read); a fade sweep passes ST_FADE (NUM_LEDS
// reads through the single fade unit, a write-back drain, the result); each ends
// with the hand-off to the output register.
// One request at a time: s_ready is high only in idle. A result holds on
// m_payload until m_ready; meanwhile the next request is worked on and then
// waits in the sequencer, so a long m_ready stall blocks s_ready.
// Synchronous active-low reset clears mode, timeout and the LED valid bits and
// loads the configuration reset values; cfg_ready is always high.
module motion_light_fade_controller_core #(
    parameter int unsigned NUM_LEDS = 83
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mlfc_pkg::in_item_t                    s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mlfc_pkg::out_item_t                   m_payload,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mlfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mlfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int unsigned ADDR_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int unsigned CNT_W  = ADDR_W + 1;
    localparam int unsigned IDX_W  = 9;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FADE = 4'b0010,
        ST_READ = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    mlfc_pkg::light_mode_t mode_reg, mode_next;
    logic [9:0]            timeout_reg, timeout_next;
    logic [7:0]            level_max_reg;
    logic [9:0]            white_min_reg, white_max_reg, red_time_reg;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [ADDR_W-1:0]     pipe_addr_reg, pipe_addr_next;
    logic                  moved_reg, moved_next;
    logic                  rd_in_range_reg, rd_in_range_next;
    mlfc_pkg::out_item_t   out_reg, out_next;
    logic                  res_vld_reg, res_vld_next;
    mlfc_pkg::out_item_t   res_reg;

    logic                  s_accept;
    logic                  res_load;
    logic                  fading;
    logic [IDX_W-1:0]      idx_ext;
    logic                  idx_in_range;
    logic                  sweep_done;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    mlfc_pkg::pixel_t      ram_rd_data;
    mlfc_pkg::pixel_t      step_pix;
    logic                  step_moved;
    mlfc_pkg::light_mode_t tick_mode;
    logic [9:0]            tick_count;
    logic [9:0]            count_dec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = res_vld_reg;
    assign m_payload = res_reg;
    assign cfg_ready = 1'b1;

    // Hand a finished result to the output register once it is free
    assign res_load     = (state_reg == ST_OUT) && (!res_vld_reg || m_ready);
    assign res_vld_next = res_load || (res_vld_reg && !m_ready);

    assign fading = (mode_reg == mlfc_pkg::MODE_TO_WHITE) ||
                    (mode_reg == mlfc_pkg::MODE_TO_RED) ||
                    (mode_reg == mlfc_pkg::MODE_TO_OFF);

    assign idx_ext      = IDX_W'(s_payload.led_index);
    assign idx_in_range = (idx_ext < IDX_W'(NUM_LEDS));
    assign sweep_done   = (rd_cnt_reg == CNT_W'(NUM_LEDS)) && !pipe_vld_reg;

    // Memory read: request address on a read, sweep counter during a fade
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_cnt_reg[ADDR_W-1:0];
        if (state_reg == ST_FADE) begin
            ram_rd_en = (rd_cnt_reg != CNT_W'(NUM_LEDS));
        end else if (s_accept && (s_payload.op == mlfc_pkg::OP_READ)) begin
            ram_rd_en   = idx_in_range;
            ram_rd_addr = idx_ext[ADDR_W-1:0];
        end
    end

    mlfc_led_ram #(
        .DEPTH  (NUM_LEDS),
        .ADDR_W (ADDR_W)
    ) u_led_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (pipe_vld_reg),
        .wr_addr (pipe_addr_reg),
        .wr_data (step_pix),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mlfc_pixel_step u_pixel_step (
        .mode      (mode_reg),
        .level_max (level_max_reg),
        .pix_in    (ram_rd_data),
        .pix_out   (step_pix),
        .moved     (step_moved)
    );

    // Timeout state machine for one tick
    assign count_dec = timeout_reg - 10'd1;

    always_comb begin
        tick_mode  = mode_reg;
        tick_count = timeout_reg;
        if (s_payload.motion) begin
            if (timeout_reg == 10'd0) begin
                if (s_payload.ambient_dark) begin
                    tick_count = white_min_reg;
                    tick_mode  = mlfc_pkg::MODE_TO_WHITE;
                end
            end else if (mode_reg == mlfc_pkg::MODE_WHITE) begin
                if (timeout_reg < white_max_reg) begin
                    tick_count = timeout_reg + 10'd1;
                end
            end else if (mode_reg == mlfc_pkg::MODE_RED) begin
                tick_count = white_min_reg;
                tick_mode  = mlfc_pkg::MODE_TO_WHITE;
            end
        end else if (timeout_reg != 10'd0) begin
            tick_count = count_dec;
            if (count_dec == 10'd0) begin
                if (mode_reg == mlfc_pkg::MODE_RED) begin
                    tick_mode = mlfc_pkg::MODE_TO_OFF;
                end else if (mode_reg == mlfc_pkg::MODE_WHITE) begin
                    tick_count = red_time_reg;
                    tick_mode  = mlfc_pkg::MODE_TO_RED;
                end
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        timeout_next     = timeout_reg;
        rd_cnt_next      = rd_cnt_reg;
        pipe_vld_next    = 1'b0;
        pipe_addr_next   = rd_cnt_reg[ADDR_W-1:0];
        moved_next       = moved_reg;
        rd_in_range_next = rd_in_range_reg;
        out_next         = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    out_next = '0;
                    case (s_payload.op)
                        mlfc_pkg::OP_TICK: begin
                            mode_next             = tick_mode;
                            timeout_next          = tick_count;
                            out_next.mode         = tick_mode;
                            out_next.timeout_left = tick_count;
                            state_next            = ST_OUT;
                        end
                        mlfc_pkg::OP_FADE: begin
                            out_next.mode         = mode_reg;
                            out_next.timeout_left = timeout_reg;
                            if (fading) begin
                                rd_cnt_next = '0;
                                moved_next  = 1'b0;
                                state_next  = ST_FADE;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        mlfc_pkg::OP_READ: begin
                            rd_in_range_next = idx_in_range;
                            state_next       = ST_READ;
                        end
                        default: begin
                            out_next.mode         = mode_reg;
                            out_next.timeout_left = timeout_reg;
                            state_next            = ST_OUT;
                        end
                    endcase
                end
            end
            ST_FADE: begin
                // Issue one read per cycle, write each result back in the following cycle
                if (rd_cnt_reg != CNT_W'(NUM_LEDS)) begin
                    pipe_vld_next = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end
                if (pipe_vld_reg && step_moved) begin
                    moved_next = 1'b1;
                end
                if (sweep_done) begin
                    if (!moved_reg) begin
                        case (mode_reg)
                            mlfc_pkg::MODE_TO_WHITE: mode_next = mlfc_pkg::MODE_WHITE;
                            mlfc_pkg::MODE_TO_RED:   mode_next = mlfc_pkg::MODE_RED;
                            default:                 mode_next = mlfc_pkg::MODE_IDLE;
                        endcase
                        out_next.mode = moved_reg ? mode_reg : mode_next;
                    end else begin
                        out_next.mode = mode_reg;
                    end
                    out_next.frame_send = 1'b1;
                    state_next          = ST_OUT;
                end
            end
            ST_READ: begin
                out_next.mode         = mode_reg;
                out_next.timeout_left = timeout_reg;
                if (rd_in_range_reg) begin
                    out_next.red_level   = ram_rd_data.r;
                    out_next.green_level = ram_rd_data.g;
                    out_next.blue_level  = ram_rd_data.b;
                end
                state_next = ST_READ == state_reg ? ST_OUT : state_reg;
            end
            ST_OUT: begin
                if (res_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mode_reg        <= mlfc_pkg::MODE_IDLE;
            timeout_reg     <= '0;
            rd_cnt_reg      <= '0;
            pipe_vld_reg    <= 1'b0;
            moved_reg       <= 1'b0;
            rd_in_range_reg <= 1'b0;
            res_vld_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            timeout_reg     <= timeout_next;
            rd_cnt_reg      <= rd_cnt_next;
            pipe_vld_reg    <= pipe_vld_next;
            moved_reg       <= moved_next;
            rd_in_range_reg <= rd_in_range_next;
            res_vld_reg     <= res_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pipe_addr_reg <= pipe_addr_next;
        out_reg       <= out_next;
        if (res_load) begin
            res_reg <= out_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_max_reg <= mlfc_pkg::LEVEL_MAX_RST;
            white_min_reg <= mlfc_pkg::WHITE_MIN_RST;
            white_max_reg <= mlfc_pkg::WHITE_MAX_RST;
            red_time_reg  <= mlfc_pkg::RED_TIME_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mlfc_pkg::CFG_LEVEL_MAX: level_max_reg <= cfg_data[7:0];
                mlfc_pkg::CFG_WHITE_MIN: white_min_reg <= cfg_data;
                mlfc_pkg::CFG_WHITE_MAX: white_max_reg <= cfg_data;
                mlfc_pkg::CFG_RED_TIME:  red_time_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A fade sweep only runs in a fading mode
    a_fade_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FADE) |-> fading)
        else $error("fade sweep outside a fading mode");

    // Mode stays fixed for the whole sweep
    a_fade_mode_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FADE) && $past(state_reg == ST_FADE)) |-> $stable(mode_reg))
        else $error("mode changed during fade sweep");

    // A fade result never carries colors
    a_frame_no_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.frame_send) |->
            ((m_payload.red_level == 8'd0) && (m_payload.green_level == 8'd0) &&
             (m_payload.blue_level == 8'd0)))
        else $error("fade result with nonzero colors");

    // No write-back outside a sweep
    a_wb_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld_reg |-> (state_reg == ST_FADE))
        else $error("memory write outside fade sweep");

endmodule

@@ rtl/mlfc_pixel_step.sv @@
// Shared fade unit: moves the three channels of one LED one level toward
// the target color of the current fade mode. Depends on mlfc_pkg.
module mlfc_pixel_step (
    input  mlfc_pkg::light_mode_t mode,
    input  logic [7:0]            level_max,
    input  mlfc_pkg::pixel_t      pix_in,
    output mlfc_pkg::pixel_t      pix_out,
    output logic                  moved
);

    logic r_up, g_up, b_up;
    logic r_dn, g_dn, b_dn;
    logic r_go_up, g_go_up, b_go_up;

    // Direction per channel: white raises all, red raises red only, off lowers all
    assign r_go_up = (mode == mlfc_pkg::MODE_TO_WHITE) || (mode == mlfc_pkg::MODE_TO_RED);
    assign g_go_up = (mode == mlfc_pkg::MODE_TO_WHITE);
    assign b_go_up = (mode == mlfc_pkg::MODE_TO_WHITE);

    // Raise below the full level, lower above zero
    assign r_up = r_go_up && (pix_in.r < level_max);
    assign g_up = g_go_up && (pix_in.g < level_max);
    assign b_up = b_go_up && (pix_in.b < level_max);
    assign r_dn = !r_go_up && (pix_in.r != 8'd0);
    assign g_dn = !g_go_up && (pix_in.g != 8'd0);
    assign b_dn = !b_go_up && (pix_in.b != 8'd0);

    always_comb begin
        pix_out = pix_in;
        if (r_up) begin
            pix_out.r = pix_in.r + 8'd1;
        end else if (r_dn) begin
            pix_out.r = pix_in.r - 8'd1;
        end
        if (g_up) begin
            pix_out.g = pix_in.g + 8'd1;
        end else if (g_dn) begin
            pix_out.g = pix_in.g - 8'd1;
        end
        if (b_up) begin
            pix_out.b = pix_in.b + 8'd1;
        end else if (b_dn) begin
            pix_out.b = pix_in.b - 8'd1;
        end
    end

    assign moved = r_up || g_up || b_up || r_dn || g_dn || b_dn;

endmodule

@@ rtl/mlfc_led_ram.sv @@
// LED color store: one write port, one registered read port, with a valid
// bit per entry so that unwritten entries read as black. Depends on mlfc_pkg.
module mlfc_led_ram #(
    parameter int unsigned DEPTH  = 83,
    parameter int unsigned ADDR_W = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  mlfc_pkg::pixel_t      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output mlfc_pkg::pixel_t      rd_data
);

    mlfc_pkg::pixel_t mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    mlfc_pkg::pixel_t rd_data_reg;
    logic             rd_hit_reg;

    // Write the array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Track written entries; reset clears them all at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule
